/* rtl/core/seu_pkg.sv */
// ----------------------------------------------------------------------------
// seu_pkg
// Types and constants shared by the endpoint transfer segmenter.
// ----------------------------------------------------------------------------
package seu_pkg;

    localparam int MPS_W = 10;
    localparam int LEN_W = 16;
    localparam int ADDR_W = 32;
    localparam int DEFAULT_LENGTH_BITS = 16;
    localparam logic [MPS_W-1:0] MPS_RESET = 10'd64;

    localparam logic [2:0] REQ_START_TX = 3'd0;
    localparam logic [2:0] REQ_START_RX = 3'd1;
    localparam logic [2:0] REQ_IN_DONE = 3'd2;
    localparam logic [2:0] REQ_OUT_DONE = 3'd3;
    localparam logic [2:0] REQ_PRESET = 3'd4;

    typedef struct packed {
        logic [2:0]        req_type;
        logic [ADDR_W-1:0] buffer_base;
        logic [ADDR_W-1:0] source_base;
        logic              copy_mode;
        logic [LEN_W-1:0]  data_len;
        logic [LEN_W-1:0]  request_len;
        logic [MPS_W-1:0]  received_len;
        logic [1:0]        toggle_preset;
    } in_word_t;

    typedef struct packed {
        logic              queue_packet;
        logic              pipe_dir;
        logic [ADDR_W-1:0] buffer_address;
        logic [ADDR_W-1:0] copy_address;
        logic [MPS_W-1:0]  packet_len;
        logic              data_toggle;
        logic              pingpong;
        logic              transfer_done;
        logic [LEN_W-1:0]  total_bytes;
        logic [LEN_W-1:0]  remaining;
    } out_word_t;

    typedef struct packed {
        logic load;
        logic rem_step;
        logic step;
    } seu_cmd_t;

    typedef struct packed {
        logic rem_needed;
        logic rem_last;
    } seu_status_t;

endpackage

/* rtl/core/seu_word_if.sv */
// ----------------------------------------------------------------------------
// seu_word_if
// Valid/ready channel carrying one word of a given type.
// ----------------------------------------------------------------------------
interface seu_word_if #(
    parameter type word_t = logic
);
    logic  valid;
    logic  ready;
    word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/seu_ctrl.sv */
// ----------------------------------------------------------------------------
// seu_ctrl
// Sequencer: accept a word, run the remainder unit when needed, issue the
// step into the output register.
// ----------------------------------------------------------------------------
module seu_ctrl
    import seu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    output logic        result_valid,
    input  logic        result_ready,
    input  seu_status_t status,
    output seu_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_EXEC
    } state_t;

    state_t state_reg;
    logic   ready_reg;
    logic   out_valid_reg;
    logic   out_free;

    assign out_free = !out_valid_reg || result_ready;

    always_comb
    begin
        cmd.load = (state_reg == ST_IDLE) && item_valid && ready_reg;
        cmd.rem_step = (state_reg == ST_RUN);
        cmd.step = (state_reg == ST_EXEC) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // a new word replaces the one leaving in the same cycle
            if (cmd.step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (item_valid && ready_reg)
                    begin
                        ready_reg <= 1'b0;
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    if (!status.rem_needed || status.rem_last)
                    begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    if (out_free)
                    begin
                        ready_reg <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign item_ready = ready_reg;
    assign result_valid = out_valid_reg;

endmodule

/* rtl/core/seu_dp.sv */
// ----------------------------------------------------------------------------
// seu_dp
// Pipe state, bit-serial remainder unit for the zero-length packet decision,
// packet step logic and output word register.
// ----------------------------------------------------------------------------
module seu_dp
    import seu_pkg::*;
#(
    parameter int LENGTH_BITS = DEFAULT_LENGTH_BITS
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  in_word_t         item_data,
    input  logic             cfg_we,
    input  logic [MPS_W-1:0] cfg_data,
    input  seu_cmd_t         cmd,
    output seu_status_t      status,
    output out_word_t        out_data
);

    localparam int LW = LENGTH_BITS;
    localparam int XW = LENGTH_BITS + MPS_W;
    localparam int REM_STEPS = LEN_W;
    localparam int REM_CW = $clog2(REM_STEPS);

    logic [MPS_W-1:0]  mps_reg;
    logic [MPS_W-1:0]  mps_eff;
    in_word_t          in_reg;
    out_word_t         out_reg;
    out_word_t         out_next;

    logic [MPS_W-1:0]  rem_reg;
    logic [MPS_W-1:0]  rem_next;
    logic [LEN_W-1:0]  div_reg;
    logic [LEN_W-1:0]  div_next;
    logic [REM_CW-1:0] rem_cnt_reg;
    logic [MPS_W:0]    rem_trial;
    logic [LEN_W-1:0]  load_clip;

    logic              tx_toggle_reg, tx_toggle_next;
    logic              tx_sel_reg, tx_sel_next;
    logic [LW-1:0]     tx_left_reg, tx_left_next;
    logic [LW-1:0]     tx_offset_reg, tx_offset_next;
    logic              tx_zlp_reg, tx_zlp_next;
    logic [ADDR_W-1:0] tx_base_reg, tx_base_next;
    logic [ADDR_W-1:0] tx_source_reg, tx_source_next;
    logic              tx_bounce_reg, tx_bounce_next;
    logic              rx_toggle_reg, rx_toggle_next;
    logic              rx_sel_reg, rx_sel_next;
    logic [LW-1:0]     rx_left_reg, rx_left_next;
    logic [LW-1:0]     rx_offset_reg, rx_offset_next;
    logic [ADDR_W-1:0] rx_base_reg, rx_base_next;

    assign mps_eff = (mps_reg == '0) ? MPS_W'(1) : mps_reg;

    // remainder of the clipped transmit length by the packet size
    assign load_clip = (item_data.data_len > item_data.request_len) ?
                       item_data.request_len : item_data.data_len;
    assign rem_trial = {rem_reg, div_reg[LEN_W-1]};

    always_comb
    begin
        div_next = {div_reg[LEN_W-2:0], 1'b0};
        if (rem_trial >= {1'b0, mps_eff})
        begin
            rem_next = MPS_W'(rem_trial - {1'b0, mps_eff});
        end
        else
        begin
            rem_next = rem_trial[MPS_W-1:0];
        end
    end

    assign status.rem_needed = (in_reg.req_type == REQ_START_TX);
    assign status.rem_last = (rem_cnt_reg == REM_CW'(REM_STEPS - 1));

    always_comb
    begin
        logic          do_tx;
        logic [LW-1:0] t_left;
        logic [LW-1:0] t_off;
        logic          t_tog;
        logic [LEN_W-1:0] clip;
        logic [MPS_W-1:0] pkt_len;
        logic [MPS_W-1:0] rx_len;
        logic [LW-1:0] rx_left_v;
        logic [LW-1:0] rx_off_v;

        tx_toggle_next = tx_toggle_reg;
        tx_sel_next = tx_sel_reg;
        tx_left_next = tx_left_reg;
        tx_offset_next = tx_offset_reg;
        tx_zlp_next = tx_zlp_reg;
        tx_base_next = tx_base_reg;
        tx_source_next = tx_source_reg;
        tx_bounce_next = tx_bounce_reg;
        rx_toggle_next = rx_toggle_reg;
        rx_sel_next = rx_sel_reg;
        rx_left_next = rx_left_reg;
        rx_offset_next = rx_offset_reg;
        rx_base_next = rx_base_reg;
        out_next = '0;

        do_tx = 1'b0;
        t_left = tx_left_reg;
        t_off = tx_offset_reg;
        t_tog = ~tx_toggle_reg;
        clip = '0;
        pkt_len = '0;
        rx_len = '0;
        rx_left_v = '0;
        rx_off_v = '0;

        unique case (in_reg.req_type)
            REQ_START_TX:
            begin
                clip = (in_reg.data_len > in_reg.request_len) ?
                       in_reg.request_len : in_reg.data_len;
                t_left = LW'(clip);
                t_off = '0;
                t_tog = tx_toggle_reg;
                tx_base_next = in_reg.buffer_base;
                tx_source_next = in_reg.source_base;
                tx_bounce_next = in_reg.copy_mode;
                tx_zlp_next = (clip < in_reg.request_len) && (rem_reg == '0);
                do_tx = 1'b1;
            end
            REQ_START_RX:
            begin
                rx_left_v = LW'(in_reg.data_len);
                rx_base_next = in_reg.buffer_base;
                rx_left_next = rx_left_v;
                rx_offset_next = '0;
                rx_len = (XW'(rx_left_v) > XW'(mps_eff)) ? mps_eff : MPS_W'(rx_left_v);
                out_next.queue_packet = 1'b1;
                out_next.buffer_address = in_reg.buffer_base;
                out_next.packet_len = rx_len;
                out_next.data_toggle = rx_toggle_reg;
                out_next.pingpong = rx_sel_reg;
                out_next.remaining = LEN_W'(rx_left_v);
            end
            REQ_IN_DONE:
            begin
                do_tx = 1'b1;
            end
            REQ_OUT_DONE:
            begin
                rx_left_v = (XW'(in_reg.received_len) > XW'(rx_left_reg)) ? '0 :
                            rx_left_reg - LW'(in_reg.received_len);
                rx_off_v = rx_offset_reg + LW'(in_reg.received_len);
                rx_toggle_next = ~rx_toggle_reg;
                rx_sel_next = ~rx_sel_reg;
                rx_left_next = rx_left_v;
                rx_offset_next = rx_off_v;
                out_next.data_toggle = ~rx_toggle_reg;
                out_next.pingpong = ~rx_sel_reg;
                out_next.total_bytes = LEN_W'(rx_off_v);
                out_next.remaining = LEN_W'(rx_left_v);
                if ((in_reg.received_len < mps_eff) || (rx_left_v == '0))
                begin
                    out_next.transfer_done = 1'b1;
                end
                else
                begin
                    rx_len = (XW'(rx_left_v) > XW'(mps_eff)) ? mps_eff :
                             MPS_W'(rx_left_v);
                    out_next.queue_packet = 1'b1;
                    out_next.buffer_address = rx_base_reg + ADDR_W'(rx_off_v);
                    out_next.packet_len = rx_len;
                end
            end
            REQ_PRESET:
            begin
                rx_toggle_next = in_reg.toggle_preset[0];
                tx_toggle_next = in_reg.toggle_preset[1];
            end
            default:
            begin
                do_tx = 1'b0;
            end
        endcase

        if (do_tx)
        begin
            tx_toggle_next = t_tog;
            out_next.pipe_dir = 1'b1;
            out_next.data_toggle = t_tog;
            tx_left_next = t_left;
            tx_offset_next = t_off;
            if (t_left != '0)
            begin
                pkt_len = (XW'(t_left) > XW'(mps_eff)) ? mps_eff : MPS_W'(t_left);
                tx_offset_next = t_off + LW'(pkt_len);
                tx_left_next = t_left - LW'(pkt_len);
                tx_sel_next = ~tx_sel_reg;
                out_next.queue_packet = 1'b1;
                out_next.packet_len = pkt_len;
                out_next.pingpong = tx_sel_reg;
                if (tx_bounce_next)
                begin
                    out_next.buffer_address = tx_base_next;
                    out_next.copy_address = tx_source_next + ADDR_W'(t_off);
                end
                else
                begin
                    out_next.buffer_address = tx_base_next + ADDR_W'(t_off);
                end
            end
            else if (tx_zlp_next)
            begin
                tx_zlp_next = 1'b0;
                tx_sel_next = ~tx_sel_reg;
                out_next.queue_packet = 1'b1;
                out_next.pingpong = tx_sel_reg;
            end
            else
            begin
                out_next.pingpong = tx_sel_reg;
                out_next.transfer_done = 1'b1;
            end
            out_next.total_bytes = LEN_W'(tx_offset_next);
            out_next.remaining = LEN_W'(tx_left_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mps_reg <= MPS_RESET;
            rem_cnt_reg <= '0;
            tx_toggle_reg <= 1'b0;
            tx_sel_reg <= 1'b0;
            tx_left_reg <= '0;
            tx_offset_reg <= '0;
            tx_zlp_reg <= 1'b0;
            tx_base_reg <= '0;
            tx_source_reg <= '0;
            tx_bounce_reg <= 1'b0;
            rx_toggle_reg <= 1'b0;
            rx_sel_reg <= 1'b0;
            rx_left_reg <= '0;
            rx_offset_reg <= '0;
            rx_base_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                mps_reg <= cfg_data;
            end
            if (cmd.load)
            begin
                rem_cnt_reg <= '0;
            end
            else if (cmd.rem_step)
            begin
                rem_cnt_reg <= rem_cnt_reg + REM_CW'(1);
            end
            if (cmd.step)
            begin
                tx_toggle_reg <= tx_toggle_next;
                tx_sel_reg <= tx_sel_next;
                tx_left_reg <= tx_left_next;
                tx_offset_reg <= tx_offset_next;
                tx_zlp_reg <= tx_zlp_next;
                tx_base_reg <= tx_base_next;
                tx_source_reg <= tx_source_next;
                tx_bounce_reg <= tx_bounce_next;
                rx_toggle_reg <= rx_toggle_next;
                rx_sel_reg <= rx_sel_next;
                rx_left_reg <= rx_left_next;
                rx_offset_reg <= rx_offset_next;
                rx_base_reg <= rx_base_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            in_reg <= item_data;
            rem_reg <= '0;
            div_reg <= load_clip;
        end
        else if (cmd.rem_step)
        begin
            rem_reg <= rem_next;
            div_reg <= div_next;
        end
        if (cmd.step)
        begin
            out_reg <= out_next;
        end
    end

    assign out_data = out_reg;

endmodule

/* rtl/core/usb_endpoint_transfer_segmenter_unit.sv */
// ----------------------------------------------------------------------------
// usb_endpoint_transfer_segmenter_unit
// Packet engine for one USB endpoint pair: segments transfers into packets.
// ----------------------------------------------------------------------------
// One word is handled at a time. A transmit start runs from its accept through
// the bit-serial remainder unit, which decides whether a zero-length packet is
// owed, to the step that loads the output register once that is free; other
// requests do not wait on the remainder unit. A finished result sits in the
// output register while the next word is accepted. max_packet_size may be
// written at any time the block is idle; zero acts as one.
module usb_endpoint_transfer_segmenter_unit
    import seu_pkg::*;
#(
    parameter int LENGTH_BITS = DEFAULT_LENGTH_BITS
)
(
    input  logic             clk,
    input  logic             rst_n,
    seu_word_if.sink         item,
    seu_word_if.source       result,
    input  logic             cfg_we,
    input  logic [MPS_W-1:0] cfg_data
);

    seu_cmd_t    cmd;
    seu_status_t status;
    out_word_t   out_data;

    seu_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item.valid),
        .item_ready   (item.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .status       (status),
        .cmd          (cmd)
    );

    seu_dp #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_data (item.data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_data  (out_data)
    );

    assign result.data = out_data;

endmodule

/* sim/tb_usb_endpoint_transfer_segmenter_unit.sv */
// ----------------------------------------------------------------------------
// tb_usb_endpoint_transfer_segmenter_unit
// Self-checking bench for the endpoint packet segmenter. A short table of
// directed words is followed by random transmit and receive transfers under
// several packet size settings. A local model of both pipes predicts each
// result word, which is checked field by field as it leaves the block.
// ----------------------------------------------------------------------------
module tb_usb_endpoint_transfer_segmenter_unit;
    import seu_pkg::*;

    localparam logic [2:0] REQ_SPARE5 = 3'd5;
    localparam logic [2:0] REQ_SPARE6 = 3'd6;
    localparam logic [2:0] REQ_SPARE7 = 3'd7;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int IDLE_PCT = 34;
    localparam int PHASE_WORDS = 190;

    typedef struct {
        in_word_t  w;
        bit        typed;
        out_word_t want;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [MPS_W-1:0] cfg_data = '0;

    seu_word_if #(.word_t(in_word_t)) item_if();
    seu_word_if #(.word_t(out_word_t)) result_if();

    usb_endpoint_transfer_segmenter_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item_if),
        .result   (result_if),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // pipe state mirror
    logic [MPS_W-1:0]  mps_cfg = MPS_RESET;
    logic              tx_tog = 1'b0;
    logic              tx_sel = 1'b0;
    logic              tx_zlp = 1'b0;
    logic              tx_bounce = 1'b0;
    logic [LEN_W-1:0]  tx_left = '0;
    logic [LEN_W-1:0]  tx_offset = '0;
    logic [ADDR_W-1:0] tx_base = '0;
    logic [ADDR_W-1:0] tx_source = '0;
    logic              rx_tog = 1'b0;
    logic              rx_sel = 1'b0;
    logic [LEN_W-1:0]  rx_left = '0;
    logic [LEN_W-1:0]  rx_offset = '0;
    logic [ADDR_W-1:0] rx_base = '0;

    out_word_t pending_results[$];
    plan_row_t plan[$];
    int errors = 0;
    int stall_cycles = 0;
    bit steady = 1'b0;

    function automatic out_word_t pack_result(bit q, bit dir, logic [ADDR_W-1:0] addr,
                                              logic [ADDR_W-1:0] caddr,
                                              logic [MPS_W-1:0] len, bit tog, bit pp,
                                              bit done, logic [LEN_W-1:0] total,
                                              logic [LEN_W-1:0] rem);
        out_word_t r;
        r.queue_packet = q;
        r.pipe_dir = dir;
        r.buffer_address = addr;
        r.copy_address = caddr;
        r.packet_len = len;
        r.data_toggle = tog;
        r.pingpong = pp;
        r.transfer_done = done;
        r.total_bytes = total;
        r.remaining = rem;
        return r;
    endfunction

    function automatic in_word_t word_in(logic [2:0] req, logic [ADDR_W-1:0] base,
                                         logic [ADDR_W-1:0] src, logic copy,
                                         logic [LEN_W-1:0] dlen, logic [LEN_W-1:0] rlen,
                                         logic [MPS_W-1:0] rcv, logic [1:0] tp);
        in_word_t w;
        w.req_type = req;
        w.buffer_base = base;
        w.source_base = src;
        w.copy_mode = copy;
        w.data_len = dlen;
        w.request_len = rlen;
        w.received_len = rcv;
        w.toggle_preset = tp;
        return w;
    endfunction

    function automatic logic [LEN_W-1:0] packet_limit();
        return (mps_cfg == '0) ? LEN_W'(1) : LEN_W'(mps_cfg);
    endfunction

    function automatic out_word_t tx_next_packet();
        logic [LEN_W-1:0]  chunk;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] caddr;
        logic              pp;
        tx_tog = ~tx_tog;
        if (tx_left != '0)
        begin
            chunk = (tx_left > packet_limit()) ? packet_limit() : tx_left;
            pp = tx_sel;
            addr = tx_bounce ? tx_base : tx_base + ADDR_W'(tx_offset);
            caddr = tx_bounce ? tx_source + ADDR_W'(tx_offset) : '0;
            tx_offset = tx_offset + chunk;
            tx_left = tx_left - chunk;
            tx_sel = ~tx_sel;
            return pack_result(1, 1, addr, caddr, chunk[MPS_W-1:0], tx_tog, pp, 0,
                               tx_offset, tx_left);
        end
        if (tx_zlp)
        begin
            pp = tx_sel;
            tx_zlp = 1'b0;
            tx_sel = ~tx_sel;
            return pack_result(1, 1, '0, '0, '0, tx_tog, pp, 0, tx_offset, tx_left);
        end
        return pack_result(0, 1, '0, '0, '0, tx_tog, tx_sel, 1, tx_offset, tx_left);
    endfunction

    function automatic out_word_t segment_step(in_word_t w);
        logic [LEN_W-1:0] mps;
        logic [LEN_W-1:0] clipped;
        logic [LEN_W-1:0] got;
        logic [LEN_W-1:0] chunk;
        out_word_t        r;
        mps = packet_limit();
        got = LEN_W'(w.received_len);
        r = '0;
        case (w.req_type)
            REQ_START_TX:
            begin
                clipped = (w.data_len > w.request_len) ? w.request_len : w.data_len;
                tx_base = w.buffer_base;
                tx_source = w.source_base;
                tx_bounce = w.copy_mode;
                tx_left = clipped;
                tx_offset = '0;
                tx_zlp = (clipped < w.request_len) && ((clipped % mps) == '0);
                tx_tog = ~tx_tog;
                r = tx_next_packet();
            end
            REQ_START_RX:
            begin
                rx_base = w.buffer_base;
                rx_left = w.data_len;
                rx_offset = '0;
                chunk = (rx_left > mps) ? mps : rx_left;
                r = pack_result(1, 0, rx_base, '0, chunk[MPS_W-1:0], rx_tog, rx_sel, 0,
                                rx_offset, rx_left);
            end
            REQ_IN_DONE:
                r = tx_next_packet();
            REQ_OUT_DONE:
            begin
                rx_tog = ~rx_tog;
                rx_left = (got > rx_left) ? '0 : rx_left - got;
                rx_offset = rx_offset + got;
                rx_sel = ~rx_sel;
                if (got < mps || rx_left == '0)
                begin
                    r = pack_result(0, 0, '0, '0, '0, rx_tog, rx_sel, 1, rx_offset, rx_left);
                end
                else
                begin
                    chunk = (rx_left > mps) ? mps : rx_left;
                    r = pack_result(1, 0, rx_base + ADDR_W'(rx_offset), '0,
                                    chunk[MPS_W-1:0], rx_tog, rx_sel, 0, rx_offset, rx_left);
                end
            end
            REQ_PRESET:
            begin
                rx_tog = w.toggle_preset[0];
                tx_tog = w.toggle_preset[1];
            end
            default:
                r = '0;
        endcase
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endfunction

    function automatic void check_result(out_word_t want, out_word_t got);
        check_field("queue_packet", want.queue_packet, got.queue_packet);
        check_field("pipe_dir", want.pipe_dir, got.pipe_dir);
        check_field("buffer_address", want.buffer_address, got.buffer_address);
        check_field("copy_address", want.copy_address, got.copy_address);
        check_field("packet_len", want.packet_len, got.packet_len);
        check_field("data_toggle", want.data_toggle, got.data_toggle);
        check_field("pingpong", want.pingpong, got.pingpong);
        check_field("transfer_done", want.transfer_done, got.transfer_done);
        check_field("total_bytes", want.total_bytes, got.total_bytes);
        check_field("remaining", want.remaining, got.remaining);
    endfunction

    function automatic void add_row(in_word_t w, bit typed = 1'b0, out_word_t want = '0);
        plan.push_back('{w, typed, want});
    endfunction

    function automatic in_word_t random_word();
        in_word_t w;
        w.req_type = 3'($urandom);
        w.buffer_base = ADDR_W'($urandom);
        w.source_base = ADDR_W'($urandom);
        w.copy_mode = 1'($urandom);
        w.data_len = LEN_W'($urandom);
        w.request_len = LEN_W'($urandom);
        w.received_len = MPS_W'($urandom);
        w.toggle_preset = 2'($urandom);
        return w;
    endfunction

    function automatic logic [LEN_W-1:0] pick_len();
        int r;
        int mps;
        r = $urandom_range(99);
        mps = int'(packet_limit());
        if (r < 10)
            return LEN_W'($urandom);
        if (r < 30)
            return LEN_W'(mps * $urandom_range(0, 4));
        return LEN_W'($urandom_range(0, mps * 4 + 3));
    endfunction

    function automatic logic [LEN_W-1:0] pick_request(logic [LEN_W-1:0] d);
        int r;
        r = $urandom_range(99);
        if (r < 35)
            return d;
        if (r < 65)
            return d + LEN_W'($urandom_range(1, 200));
        if (r < 85)
            return LEN_W'($urandom_range(0, int'(d)));
        return LEN_W'($urandom);
    endfunction

    task automatic send_word(input in_word_t w, output out_word_t pred,
                             input bit typed = 1'b0, input out_word_t want = '0);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            item_if.valid <= 1'b0;
            @(posedge clk);
        end
        item_if.valid <= 1'b1;
        item_if.data <= w;
        do
            @(posedge clk);
        while (!item_if.ready);
        pred = segment_step(w);
        pending_results.push_back(typed ? want : pred);
    endtask

    task automatic write_mps(logic [MPS_W-1:0] v);
        item_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (24) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        mps_cfg = v;
    endtask

    task automatic run_phase(int target);
        int               fed;
        int               kind;
        int               steps;
        int               r;
        logic [LEN_W-1:0] mps;
        in_word_t         w;
        out_word_t        pred;
        fed = 0;
        while (fed < target)
        begin
            mps = packet_limit();
            kind = $urandom_range(99);
            w = random_word();
            if (kind < 40)
            begin
                w.req_type = REQ_START_TX;
                w.data_len = pick_len();
                w.request_len = pick_request(w.data_len);
                send_word(w, pred);
                fed++;
                steps = 0;
                while ((!pred.transfer_done && steps < 24) || $urandom_range(99) < 10)
                begin
                    w = random_word();
                    w.req_type = REQ_IN_DONE;
                    send_word(w, pred);
                    fed++;
                    steps++;
                end
            end
            else if (kind < 80)
            begin
                w.req_type = REQ_START_RX;
                w.data_len = pick_len();
                send_word(w, pred);
                fed++;
                steps = 0;
                while ((!pred.transfer_done && steps < 24) || $urandom_range(99) < 10)
                begin
                    w = random_word();
                    w.req_type = REQ_OUT_DONE;
                    r = $urandom_range(99);
                    if (r < 75)
                        w.received_len = mps[MPS_W-1:0];
                    else if (r < 90)
                        w.received_len = MPS_W'($urandom_range(0, int'(mps) - 1));
                    send_word(w, pred);
                    fed++;
                    steps++;
                end
            end
            else
            begin
                send_word(w, pred);
                if (w.req_type <= REQ_PRESET)
                    fed++;
            end
        end
    endtask

    // result side: random back-pressure (none in the steady phase) and checking
    initial
    begin
        result_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_if.valid && result_if.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result word with nothing pending");
                    errors++;
                end
                else
                begin
                    check_result(pending_results.pop_front(), result_if.data);
                end
            end
            result_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_if.valid && item_if.ready) || (result_if.valid && result_if.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        logic [MPS_W-1:0] settings[7];
        out_word_t        pred;
        item_if.valid <= 1'b0;
        item_if.data <= '0;
        settings = '{10'd1023, 10'd1, 10'd0, 10'd7, 10'd64, 10'd0, 10'd512};
        settings[5] = MPS_W'($urandom_range(2, 1022));

        add_row(word_in(REQ_IN_DONE, '0, '0, 1'b0, '0, '0, '0, 2'b00), 1'b1,
                pack_result(0, 1, '0, '0, '0, 1, 0, 1, '0, '0));
        add_row(word_in(REQ_OUT_DONE, '0, '0, 1'b0, '0, '0, '0, 2'b00), 1'b1,
                pack_result(0, 0, '0, '0, '0, 1, 1, 1, '0, '0));
        add_row(word_in(REQ_PRESET, '0, '0, 1'b0, '0, '0, '0, 2'b11), 1'b1, '0);
        add_row(word_in(REQ_SPARE5, '1, '1, 1'b1, '1, '1, '1, 2'b11), 1'b1, '0);
        add_row(word_in(REQ_SPARE6, 32'h1234_5678, 32'h9abc_def0, 1'b1, 16'd100, 16'd50,
                        10'd64, 2'b01), 1'b1, '0);
        add_row(word_in(REQ_SPARE7, '1, '0, 1'b0, 16'd1, '1, 10'd1, 2'b10), 1'b1, '0);
        add_row(word_in(REQ_START_TX, '1, '1, 1'b1, 16'hffff, 16'hffff, '0, 2'b00));
        add_row(word_in(REQ_IN_DONE, '0, '0, 1'b0, '0, '0, '0, 2'b00));
        add_row(word_in(REQ_START_TX, 32'h2000_0000, '0, 1'b0, 16'd128, 16'd200, '0, 2'b00));
        repeat (3) add_row(word_in(REQ_IN_DONE, '0, '0, 1'b0, '0, '0, '0, 2'b00));
        add_row(word_in(REQ_START_TX, 32'h3000_0000, '0, 1'b0, 16'd0, 16'd0, '0, 2'b00));
        add_row(word_in(REQ_START_TX, 32'h3000_0000, '0, 1'b0, 16'd0, 16'd5, '0, 2'b00));
        add_row(word_in(REQ_IN_DONE, '0, '0, 1'b0, '0, '0, '0, 2'b00));
        add_row(word_in(REQ_START_TX, 32'h4000_0000, 32'h8000_0000, 1'b1, 16'd300, 16'd100,
                        '0, 2'b00));
        add_row(word_in(REQ_IN_DONE, '0, '0, 1'b0, '0, '0, '0, 2'b00));
        add_row(word_in(REQ_START_RX, 32'h0000_1000, '0, 1'b0, 16'd130, '0, '0, 2'b00));
        add_row(word_in(REQ_OUT_DONE, '0, '0, 1'b0, '0, '0, 10'd64, 2'b00));
        add_row(word_in(REQ_OUT_DONE, '0, '0, 1'b0, '0, '0, 10'd1023, 2'b00));
        add_row(word_in(REQ_START_RX, 32'h0000_2000, '0, 1'b0, 16'd0, '0, '0, 2'b00));
        add_row(word_in(REQ_START_RX, 32'hffff_fff0, '0, 1'b0, 16'hffff, '0, '0, 2'b00));
        add_row(word_in(REQ_OUT_DONE, '0, '0, 1'b0, '0, '0, 10'd10, 2'b00));
        add_row(word_in(REQ_PRESET, '0, '0, 1'b0, '0, '0, '0, 2'b01));
        add_row(word_in(REQ_PRESET, '0, '0, 1'b0, '0, '0, '0, 2'b10));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            send_word(plan[i].w, pred, plan[i].typed, plan[i].want);

        for (int p = 0; p < 7; p++)
        begin
            write_mps(settings[p]);
            steady = (p == 4);
            run_phase(PHASE_WORDS);
            steady = 1'b0;
        end

        item_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* files.f */
rtl/core/seu_pkg.sv
rtl/core/seu_word_if.sv
rtl/core/seu_ctrl.sv
rtl/core/seu_dp.sv
rtl/core/usb_endpoint_transfer_segmenter_unit.sv
sim/tb_usb_endpoint_transfer_segmenter_unit.sv
